### rtl/escape_time_fractal_pixel_assert.svh
// Assertion macros shared by the escape-time fractal pixel design.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ETF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/etf_pkg.sv
package etf_pkg;

    localparam int CoordWidth = 32;
    localparam int FracBits   = 28;
    localparam int ProdWidth  = 2 * CoordWidth;
    localparam int LimitWidth = 16;

    localparam logic signed [CoordWidth-1:0] VMax = {1'b0, {(CoordWidth-1){1'b1}}};
    localparam logic signed [CoordWidth-1:0] VMin = {1'b1, {(CoordWidth-1){1'b0}}};

    // Fixed-point constants, rounded half up.
    localparam logic signed [CoordWidth-1:0] FixOne = CoordWidth'(64'd1 << FracBits);
    localparam logic signed [CoordWidth-1:0] LamRe0 =
        CoordWidth'(((64'd85 << FracBits) + 64'd50) / 64'd100);
    localparam logic signed [CoordWidth-1:0] LamRe1 =
        CoordWidth'(((64'd86 << FracBits) + 64'd50) / 64'd100);
    localparam logic signed [CoordWidth-1:0] LamRe2 =
        CoordWidth'(((64'd87 << FracBits) + 64'd50) / 64'd100);
    localparam logic signed [CoordWidth-1:0] LamIm =
        CoordWidth'(((64'd6 << FracBits) + 64'd5) / 64'd10);

    typedef enum logic [1:0] {
        MODE_MANDEL = 2'd0,
        MODE_JULIA  = 2'd1,
        MODE_LAMBDA = 2'd2,
        MODE_OTHER  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_EXP    = 3'd2,
        REG_JRED   = 3'd3,
        REG_JGREEN = 3'd4,
        REG_JBLUE  = 3'd5
    } reg_idx_t;

endpackage

### rtl/escape_time_fractal_pixel.sv
// Sequence: per channel a setup state, a bound check (ST_MAG, ST_CHECK) before every
// iteration and after the last one, and a hand-off state. An iteration runs one complex
// multiply (ST_PROD, ST_CMB) per power, exponent-1 of them, then adds c, or in Lambda
// mode two multiplies with a 1 - z step between. ST_DONE holds the item until out_stall is low.
// Throughput: one item at a time; the shared 32x32 multiplier sets the rate.
// Reset: asynchronous, active low; only the state and configuration registers are reset.
`include "escape_time_fractal_pixel_assert.svh"

module escape_time_fractal_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] point_re,
    input  logic signed [31:0] point_im,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_count,
    output logic [7:0]  green_count,
    output logic [7:0]  blue_count
);

    localparam int W  = etf_pkg::CoordWidth;
    localparam int PW = etf_pkg::ProdWidth;
    localparam int F  = etf_pkg::FracBits;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SETUP = 10'b0000000010,
        ST_MAG   = 10'b0000000100,  // square terms of |z|^2
        ST_CHECK = 10'b0000001000,
        ST_PROD  = 10'b0000010000,  // four partial products of a complex multiply
        ST_CMB   = 10'b0000100000,  // combine into a complex result
        ST_ADDC  = 10'b0001000000,
        ST_LAMD  = 10'b0010000000,
        ST_NEXT  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [15:0] limit_reg;
    logic [3:0]  exp_reg;
    logic [63:0] julia_reg [3];

    // Datapath registers.
    logic signed [W-1:0] pt_re_reg, pt_im_reg;
    logic signed [W-1:0] z_re_reg, z_im_reg, z_re_next, z_im_next;
    logic signed [W-1:0] p_re_reg, p_im_reg, p_re_next, p_im_next;
    logic signed [W-1:0] c_re_reg, c_im_reg, c_re_next, c_im_next;
    logic signed [W-1:0] d_re_reg, d_im_reg, d_re_next, d_im_next;
    logic signed [W-1:0] op_a, op_b;
    logic signed [PW-1:0] prod_reg [4];
    logic [PW:0]  mag_reg, mag_next;
    logic [1:0]   pidx_reg, pidx_next;
    logic [1:0]   ch_reg, ch_next;
    logic [3:0]   mcnt_reg, mcnt_next;
    logic         lstage_reg, lstage_next;
    logic         ovf_reg, ovf_next;
    logic [15:0]  cnt_reg, cnt_next;
    logic [7:0]   res_reg [3];
    logic [3:0]   n_eff;
    logic signed [PW-1:0] prod;
    logic signed [W+1:0]  sum_re, sum_im;
    logic signed [W-1:0]  fm [4];
    logic                 fo [4];
    logic signed [W:0]    add_re, add_im;
    logic signed [W-1:0]  cmb_re, cmb_im;
    logic                 cmb_ovf;
    logic [PW:0]          bound;

    assign n_eff = (exp_reg < 4'd2) ? 4'd2 : ((exp_reg > 4'd8) ? 4'd8 : exp_reg);
    assign bound = (PW + 1)'(1) << (2 * F + 2);

    // Shared signed multiplier, operands chosen by the sequencer.
    always_comb
    begin
        op_a = p_re_reg;
        op_b = d_re_reg;
        if (state_reg == ST_MAG) begin
            op_a = pidx_reg[0] ? z_im_reg : z_re_reg;
            op_b = op_a;
        end else begin
            unique case (pidx_reg)
                2'd0:
                begin
                    op_a = p_re_reg; op_b = d_re_reg;
                end
                2'd1:
                begin
                    op_a = p_im_reg; op_b = d_im_reg;
                end
                2'd2:
                begin
                    op_a = p_re_reg; op_b = d_im_reg;
                end
                default:
                begin
                    op_a = p_im_reg; op_b = d_re_reg;
                end
            endcase
        end
    end

    assign prod = PW'(op_a) * PW'(op_b);

    // Floor-shift each product and saturate.
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            logic signed [PW-F-1:0] q;
            q = prod_reg[i][PW-1:F];
            if (q > (PW-F)'(etf_pkg::VMax)) begin
                fm[i] = etf_pkg::VMax; fo[i] = 1'b1;
            end else if (q < (PW-F)'(etf_pkg::VMin)) begin
                fm[i] = etf_pkg::VMin; fo[i] = 1'b1;
            end else begin
                fm[i] = W'(q); fo[i] = 1'b0;
            end
        end
        sum_re = (W+2)'(fm[0]) - (W+2)'(fm[1]);
        sum_im = (W+2)'(fm[2]) + (W+2)'(fm[3]);
        cmb_ovf = fo[0] | fo[1] | fo[2] | fo[3];
        if (sum_re > (W+2)'(etf_pkg::VMax)) begin
            cmb_re = etf_pkg::VMax; cmb_ovf = 1'b1;
        end else if (sum_re < (W+2)'(etf_pkg::VMin)) begin
            cmb_re = etf_pkg::VMin; cmb_ovf = 1'b1;
        end else begin
            cmb_re = W'(sum_re);
        end
        if (sum_im > (W+2)'(etf_pkg::VMax)) begin
            cmb_im = etf_pkg::VMax; cmb_ovf = 1'b1;
        end else if (sum_im < (W+2)'(etf_pkg::VMin)) begin
            cmb_im = etf_pkg::VMin; cmb_ovf = 1'b1;
        end else begin
            cmb_im = W'(sum_im);
        end
    end

    assign add_re = (W+1)'(p_re_reg) + (W+1)'(c_re_reg);
    assign add_im = (W+1)'(p_im_reg) + (W+1)'(c_im_reg);

    // Sequencer.
    always_comb
    begin
        logic signed [W:0] dr;
        logic signed [W:0] di;
        logic signed [W-1:0] sre;
        logic signed [W-1:0] sim;
        logic                so;
        dr = '0;
        di = '0;
        sre = '0;
        sim = '0;
        so = 1'b0;
        state_next  = state_reg;
        z_re_next   = z_re_reg;
        z_im_next   = z_im_reg;
        p_re_next   = p_re_reg;
        p_im_next   = p_im_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        d_re_next   = d_re_reg;
        d_im_next   = d_im_reg;
        mag_next    = mag_reg;
        pidx_next   = pidx_reg;
        ch_next     = ch_reg;
        mcnt_next   = mcnt_reg;
        lstage_next = lstage_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    ch_next = 2'd0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
                pidx_next = 2'd0;
                mag_next = '0;
                unique case (etf_pkg::mode_t'(mode_reg))
                    etf_pkg::MODE_JULIA:
                    begin
                        z_re_next = pt_re_reg;
                        z_im_next = pt_im_reg;
                        c_re_next = julia_reg[ch_reg][31:0];
                        c_im_next = julia_reg[ch_reg][63:32];
                    end
                    etf_pkg::MODE_LAMBDA:
                    begin
                        z_re_next = pt_re_reg;
                        z_im_next = pt_im_reg;
                        c_re_next = (ch_reg == 2'd0) ? etf_pkg::LamRe0 :
                                    ((ch_reg == 2'd1) ? etf_pkg::LamRe1 : etf_pkg::LamRe2);
                        c_im_next = etf_pkg::LamIm;
                    end
                    default:
                    begin
                        z_re_next = '0;
                        z_im_next = '0;
                        c_re_next = pt_re_reg;
                        c_im_next = pt_im_reg;
                    end
                endcase
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                mag_next = mag_reg + (PW+1)'(unsigned'(prod));
                pidx_next = pidx_reg + 2'd1;
                if (pidx_reg[0])
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                pidx_next = 2'd0;
                mag_next = '0;
                if (cnt_reg >= limit_reg || mag_reg > bound || ovf_reg) begin
                    state_next = ST_NEXT;
                end else if (mode_reg == etf_pkg::MODE_LAMBDA) begin
                    // First L*z, then times (1 - z).
                    p_re_next = c_re_reg;
                    p_im_next = c_im_reg;
                    d_re_next = z_re_reg;
                    d_im_next = z_im_reg;
                    lstage_next = 1'b0;
                    state_next = ST_PROD;
                end else begin
                    p_re_next = z_re_reg;
                    p_im_next = z_im_reg;
                    d_re_next = z_re_reg;
                    d_im_next = z_im_reg;
                    mcnt_next = 4'd1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                pidx_next = pidx_reg + 2'd1;
                if (pidx_reg == 2'd3)
                    state_next = ST_CMB;
            end
            ST_CMB:
            begin
                p_re_next = cmb_re;
                p_im_next = cmb_im;
                ovf_next = ovf_reg | cmb_ovf;
                pidx_next = 2'd0;
                if (mode_reg == etf_pkg::MODE_LAMBDA) begin
                    if (!lstage_reg) begin
                        lstage_next = 1'b1;
                        state_next = ST_LAMD;
                    end else begin
                        z_re_next = cmb_re;
                        z_im_next = cmb_im;
                        cnt_next = cnt_reg + 16'd1;
                        state_next = ST_MAG;
                    end
                end else begin
                    mcnt_next = mcnt_reg + 4'd1;
                    if (mcnt_reg + 4'd1 >= n_eff)
                        state_next = ST_ADDC;
                    else
                        state_next = ST_PROD;
                end
            end
            ST_LAMD:
            begin
                dr = (W+1)'(etf_pkg::FixOne) - (W+1)'(z_re_reg);
                di = -(W+1)'(z_im_reg);
                so = 1'b0;
                if (dr > (W+1)'(etf_pkg::VMax)) begin
                    sre = etf_pkg::VMax; so = 1'b1;
                end else if (dr < (W+1)'(etf_pkg::VMin)) begin
                    sre = etf_pkg::VMin; so = 1'b1;
                end else begin
                    sre = W'(dr);
                end
                if (di > (W+1)'(etf_pkg::VMax)) begin
                    sim = etf_pkg::VMax; so = 1'b1;
                end else begin
                    sim = W'(di);
                end
                d_re_next = sre;
                d_im_next = sim;
                ovf_next = ovf_reg | so;
                state_next = ST_PROD;
            end
            ST_ADDC:
            begin
                so = 1'b0;
                if (add_re > (W+1)'(etf_pkg::VMax)) begin
                    z_re_next = etf_pkg::VMax; so = 1'b1;
                end else if (add_re < (W+1)'(etf_pkg::VMin)) begin
                    z_re_next = etf_pkg::VMin; so = 1'b1;
                end else begin
                    z_re_next = W'(add_re);
                end
                if (add_im > (W+1)'(etf_pkg::VMax)) begin
                    z_im_next = etf_pkg::VMax; so = 1'b1;
                end else if (add_im < (W+1)'(etf_pkg::VMin)) begin
                    z_im_next = etf_pkg::VMin; so = 1'b1;
                end else begin
                    z_im_next = W'(add_im);
                end
                ovf_next = ovf_reg | so;
                cnt_next = cnt_reg + 16'd1;
                pidx_next = 2'd0;
                state_next = ST_MAG;
            end
            ST_NEXT:
            begin
                if (ch_reg == 2'd2) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next = ch_reg + 2'd1;
                    state_next = ST_SETUP;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            mode_reg <= 2'd0;
            limit_reg <= 16'd256;
            exp_reg <= 4'd2;
            julia_reg[0] <= 64'd69175292885603451;
            julia_reg[1] <= 64'd69175292888287805;
            julia_reg[2] <= 64'd69175292890972160;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (etf_pkg::reg_idx_t'(cfg_index))
                    etf_pkg::REG_MODE:   mode_reg <= cfg_data[1:0];
                    etf_pkg::REG_LIMIT:  limit_reg <= cfg_data[15:0];
                    etf_pkg::REG_EXP:    exp_reg <= cfg_data[3:0];
                    etf_pkg::REG_JRED:   julia_reg[0] <= cfg_data;
                    etf_pkg::REG_JGREEN: julia_reg[1] <= cfg_data;
                    etf_pkg::REG_JBLUE:  julia_reg[2] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid) begin
            pt_re_reg <= point_re;
            pt_im_reg <= point_im;
        end
        z_re_reg <= z_re_next;
        z_im_reg <= z_im_next;
        p_re_reg <= p_re_next;
        p_im_reg <= p_im_next;
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        d_re_reg <= d_re_next;
        d_im_reg <= d_im_next;
        mag_reg <= mag_next;
        pidx_reg <= pidx_next;
        ch_reg <= ch_next;
        mcnt_reg <= mcnt_next;
        lstage_reg <= lstage_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        if (state_reg == ST_PROD)
            prod_reg[pidx_reg] <= prod;
        if (state_reg == ST_NEXT)
            res_reg[ch_reg] <= cnt_reg[7:0];
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign red_count   = res_reg[0];
    assign green_count = res_reg[1];
    assign blue_count  = res_reg[2];

    `ETF_ASSERT(a_onehot, $onehot(state_reg), "state not one-hot")
    `ETF_ASSERT_IMPL(a_cnt_lim, state_reg == ST_NEXT, cnt_reg <= limit_reg, "count beyond limit")
    `ETF_ASSERT(a_ch, (ch_reg <= 2'd2) || (state_reg == ST_IDLE), "channel out of range")
    `ETF_ASSERT_NEXT(a_done, out_valid && out_stall, out_valid, "result dropped")

endmodule

### tb/tb_escape_time_fractal_pixel.sv
`timescale 1ns / 100ps

// Testbench for the escape-time fractal pixel engine.
// A scoreboard object keeps its own copy of the configuration and predicts the
// three channel counts of every accepted item. Results are compared in order.
module tb_escape_time_fractal_pixel;

    // Cycles with no item accepted on either side before the run is aborted.
    // The slowest item here is a bounded point with the limit of 300 and
    // exponent two, so this leaves a wide margin.
    localparam int WatchdogLimit = 200000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_counts_t;

    // Scoreboard: mirrors the configuration, predicts counts, checks results.
    class pixel_scoreboard;
        etf_pkg::mode_t mode;
        logic [15:0]    limit;
        logic [3:0]     exponent;
        logic [63:0]    julia [3];
        pixel_counts_t  pending [$];
        int             errors;
        int             checked;

        function new();
            mode     = etf_pkg::MODE_MANDEL;
            limit    = 16'd256;
            exponent = 4'd2;
            julia[0] = 64'd69175292885603451;
            julia[1] = 64'd69175292888287805;
            julia[2] = 64'd69175292890972160;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(etf_pkg::reg_idx_t idx, logic [63:0] data);
            case (idx)
                etf_pkg::REG_MODE:   mode = etf_pkg::mode_t'(data[1:0]);
                etf_pkg::REG_LIMIT:  limit = data[15:0];
                etf_pkg::REG_EXP:    exponent = data[3:0];
                etf_pkg::REG_JRED:   julia[0] = data;
                etf_pkg::REG_JGREEN: julia[1] = data;
                etf_pkg::REG_JBLUE:  julia[2] = data;
                default:    ;
            endcase
        endfunction

        function longint clip(longint v, inout bit ovf);
            if (v > longint'(etf_pkg::VMax))
            begin
                ovf = 1'b1;
                return longint'(etf_pkg::VMax);
            end
            if (v < longint'(etf_pkg::VMin))
            begin
                ovf = 1'b1;
                return longint'(etf_pkg::VMin);
            end
            return v;
        endfunction

        // Exact product, arithmetic shift gives floor rounding.
        function longint fix_mul(longint a, longint b, inout bit ovf);
            longint p;
            p = a * b;
            return clip(p >>> etf_pkg::FracBits, ovf);
        endfunction

        function void cplx_mul(longint ar, longint ai, longint br, longint bi,
                               output longint rr, output longint ri, inout bit ovf);
            longint t1, t2, t3, t4;
            t1 = fix_mul(ar, br, ovf);
            t2 = fix_mul(ai, bi, ovf);
            t3 = fix_mul(ar, bi, ovf);
            t4 = fix_mul(ai, br, ovf);
            rr = clip(t1 - t2, ovf);
            ri = clip(t3 + t4, ovf);
        endfunction

        // |z|^2 <= 4 computed exactly; each square is at most 2^62.
        function bit inside_radius(longint zr, longint zi);
            logic [63:0] s;
            s = 64'(zr * zr) + 64'(zi * zi);
            return s <= (64'd4 << (2 * etf_pkg::FracBits));
        endfunction

        function logic [7:0] escape_count(longint zr, longint zi, longint cr, longint ci,
                                          bit lambda, longint lr, longint li, int n);
            int unsigned cnt;
            bit ovf;
            longint pr, pi, dr, di, qr, qi;
            cnt = 0;
            while (cnt < limit && inside_radius(zr, zi))
            begin
                ovf = 1'b0;
                if (lambda)
                begin
                    dr = clip(longint'(etf_pkg::FixOne) - zr, ovf);
                    di = clip(-zi, ovf);
                    cplx_mul(lr, li, zr, zi, qr, qi, ovf);
                    cplx_mul(qr, qi, dr, di, zr, zi, ovf);
                end
                else
                begin
                    pr = zr;
                    pi = zi;
                    for (int k = 1; k < n; k++)
                    begin
                        cplx_mul(pr, pi, zr, zi, qr, qi, ovf);
                        pr = qr;
                        pi = qi;
                    end
                    zr = clip(pr + cr, ovf);
                    zi = clip(pi + ci, ovf);
                end
                cnt++;
                if (ovf)
                    break;
            end
            return cnt[7:0];
        endfunction

        function void note_input(logic signed [31:0] re, logic signed [31:0] im);
            pixel_counts_t e;
            logic [7:0] cnt [3];
            int n;
            longint lam_re [3];
            lam_re[0] = longint'(etf_pkg::LamRe0);
            lam_re[1] = longint'(etf_pkg::LamRe1);
            lam_re[2] = longint'(etf_pkg::LamRe2);
            n = (exponent < 2) ? 2 : ((exponent > 8) ? 8 : int'(exponent));
            for (int ch = 0; ch < 3; ch++)
            begin
                if (mode == etf_pkg::MODE_JULIA)
                    cnt[ch] = escape_count(re, im, longint'(signed'(julia[ch][31:0])),
                                           longint'(signed'(julia[ch][63:32])), 1'b0, 0, 0, n);
                else if (mode == etf_pkg::MODE_LAMBDA)
                    cnt[ch] = escape_count(re, im, 0, 0, 1'b1, lam_re[ch],
                                           longint'(etf_pkg::LamIm), n);
                else
                    cnt[ch] = escape_count(0, 0, re, im, 1'b0, 0, 0, n);
            end
            e.red   = cnt[0];
            e.green = cnt[1];
            e.blue  = cnt[2];
            pending.push_back(e);
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pixel_counts_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, r, g, b);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r !== e.red)
            begin
                $display("%0t: red_count expected %0d actual %0d", $time, e.red, r);
                errors++;
            end
            if (g !== e.green)
            begin
                $display("%0t: green_count expected %0d actual %0d", $time, e.green, g);
                errors++;
            end
            if (b !== e.blue)
            begin
                $display("%0t: blue_count expected %0d actual %0d", $time, e.blue, b);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         red_count;
    logic [7:0]         green_count;
    logic [7:0]         blue_count;

    pixel_scoreboard sb;
    bit              steady;      // When set, neither side idles.
    int              quiet_cycles;
    int              items_sent;

    escape_time_fractal_pixel i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_re    (point_re),
        .point_im    (point_im),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Receiving side. Signals are read in the active region of the edge, so
    // they still hold the values that the edge sampled.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(red_count, green_count, blue_count);
        out_stall <= (!steady && $urandom_range(99) < 16);
    end

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.pending.size());
            $display("escape_time_fractal_pixel: mismatch");
            $finish;
        end
    end

    // Offers one point and waits until the block takes it. A random gap may
    // come first; the valid is only lowered when such a gap is taken.
    task automatic send_point(logic signed [31:0] re, logic signed [31:0] im);
        if (!steady && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            point_re <= $urandom;
            point_im <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_valid <= 1'b1;
        point_re <= re;
        point_im <= im;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(re, im);
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the block drained and idle.
    task automatic write_reg(etf_pkg::reg_idx_t idx, logic [63:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Random point: mostly within 2.2 of the origin on each axis, some
    // within 0.5 of the origin on each axis, the rest anywhere.
    function automatic logic signed [31:0] rand_coord();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return $signed($urandom_range(0, 1181116006)) - 32'sd590558003;
        else if (sel < 75)
            return $signed($urandom_range(0, 268435456)) - 32'sd134217728;
        else
            return $urandom;
    endfunction

    // Random Julia constant, usually a small value, sometimes any bits at all.
    function automatic logic [63:0] rand_julia();
        logic [31:0] re, im;
        if ($urandom_range(3) == 0)
            return {$urandom, $urandom};
        re = $signed($urandom_range(0, 536870912)) - 32'sd268435456;
        im = $signed($urandom_range(0, 536870912)) - 32'sd268435456;
        return {im, re};
    endfunction

    initial
    begin
        sb           = new();
        steady       = 1'b0;
        items_sent   = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = etf_pkg::REG_MODE;
        cfg_data     = 64'd0;
        in_valid     = 1'b0;
        point_re     = 32'sd0;
        point_im     = 32'sd0;
        out_stall    = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: Mandelbrot, limit 256, squares. The origin and
        // minus two never escape, so their count of 256 wraps to zero. Plus two
        // sits exactly on the radius and escapes one step later.
        send_point(32'sd0, 32'sd0);
        send_point(-32'sd536870912, 32'sd0);
        send_point(32'sd536870912, 32'sd0);
        send_point(32'sd67108864, 32'sd0);
        send_point(etf_pkg::VMax, etf_pkg::VMax);
        send_point(etf_pkg::VMin, etf_pkg::VMin);
        send_point(etf_pkg::VMax, etf_pkg::VMin);
        send_point(32'sd0, -32'sd1);

        // Reset Julia constants, then a count above 255 with mode three.
        write_reg(etf_pkg::REG_MODE, 64'(etf_pkg::MODE_JULIA));
        send_point(32'sd0, 32'sd0);
        send_point(32'sd26843545, -32'sd26843545);
        send_point(etf_pkg::VMin, etf_pkg::VMax);
        write_reg(etf_pkg::REG_MODE, 64'(etf_pkg::MODE_OTHER));
        write_reg(etf_pkg::REG_LIMIT, 64'd300);
        send_point(32'sd0, 32'sd0);

        // Lambda iteration with a short limit, including the saturation corner.
        write_reg(etf_pkg::REG_MODE, 64'(etf_pkg::MODE_LAMBDA));
        write_reg(etf_pkg::REG_LIMIT, 64'd40);
        send_point(32'sd134217728, 32'sd0);
        send_point(32'sd0, 32'sd0);
        send_point(etf_pkg::VMax, etf_pkg::VMax);

        // Exponent extremes, both out of range, and the largest power.
        write_reg(etf_pkg::REG_MODE, 64'(etf_pkg::MODE_MANDEL));
        write_reg(etf_pkg::REG_EXP, 64'd0);
        send_point(32'sd26843545, 32'sd53687091);
        write_reg(etf_pkg::REG_EXP, 64'd15);
        send_point(32'sd26843545, 32'sd53687091);
        write_reg(etf_pkg::REG_EXP, 64'd8);
        send_point(-32'sd268435456, 32'sd0);

        // Limit zero gives no iterations; the largest limit with far points.
        write_reg(etf_pkg::REG_LIMIT, 64'd0);
        send_point(32'sd0, 32'sd0);
        write_reg(etf_pkg::REG_LIMIT, 64'd65535);
        send_point(etf_pkg::VMax, 32'sd0);
        send_point(32'sd0, etf_pkg::VMin);
        write_reg(etf_pkg::REG_JRED, {32'sd0, etf_pkg::VMax});
        write_reg(etf_pkg::REG_JGREEN, {etf_pkg::VMin, etf_pkg::VMin});
        write_reg(etf_pkg::REG_JBLUE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(etf_pkg::REG_MODE, 64'(etf_pkg::MODE_JULIA));
        write_reg(etf_pkg::REG_EXP, 64'd2);
        write_reg(etf_pkg::REG_LIMIT, 64'd30);
        send_point(32'sd0, 32'sd0);

        // Random phases: each drains the block, picks a new configuration and
        // sends a batch of points. The first phase runs without any idling.
        for (int ph = 0; ph < 11; ph++)
        begin
            steady = (ph == 0);
            write_reg(etf_pkg::REG_MODE, 64'($urandom_range(3)));
            write_reg(etf_pkg::REG_LIMIT,
                      ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 32)));
            write_reg(etf_pkg::REG_EXP, 64'($urandom_range(15)));
            write_reg(etf_pkg::REG_JRED, rand_julia());
            write_reg(etf_pkg::REG_JGREEN, rand_julia());
            write_reg(etf_pkg::REG_JBLUE, rand_julia());
            for (int i = 0; i < 50; i++)
                send_point(rand_coord(), rand_coord());
        end
        steady = 1'b0;

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d points over Mandelbrot, Julia, Lambda and mode three, %0d checked.",
                 items_sent, sb.checked);
        $display("Limits from zero to 65535 and exponents from zero to fifteen were used.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("escape_time_fractal_pixel: match");
        else
            $display("escape_time_fractal_pixel: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/etf_pkg.sv
rtl/escape_time_fractal_pixel.sv
tb/tb_escape_time_fractal_pixel.sv
